@@ src/mc2d_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the mirrored 2D convolution block.
package mc2d_pkg;

	localparam int POS_BITS      = 11;
	localparam int DIM_BITS      = 12;
	localparam int HALF_BITS     = 2;
	localparam int CIDX_BITS     = 5;
	localparam int CMD_BITS      = 2;
	localparam int MAX_HEIGHT    = 2048;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 12'd480;
	localparam logic [HALF_BITS-1:0] HALF_RESET   = 2'd1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_COEF  = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_DRAIN = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_HALF   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]  width;
		logic [DIM_BITS-1:0]  height;
		logic [HALF_BITS-1:0] half;
		logic                 restart;
	} cfg_regs_t;

	typedef struct packed {
		logic                valid;
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic                last;
	} emit_t;

	// reflect across the frame edges, then clamp into 0..dim-1
	function automatic int mirror(input int i, input int dim);
		int m;
		m = i;
		if (m < 0) begin
			m = -m;
		end else if (m >= dim) begin
			m = 2 * dim - m - 1;
		end
		if (m < 0) begin
			m = 0;
		end
		if (m >= dim) begin
			m = dim - 1;
		end
		return m;
	endfunction

endpackage

@@ src/mc2d_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interfaces for command items and filtered results.
interface mc2d_in_if #(
	parameter int PIXEL_BITS = 16,
	parameter int COEF_BITS  = 16
);
	logic                                 valid;
	logic                                 ready;
	logic [mc2d_pkg::CMD_BITS-1:0]        command;
	logic [mc2d_pkg::CIDX_BITS-1:0]       coef_index;
	logic signed [COEF_BITS-1:0]          coef_value;
	logic [PIXEL_BITS-1:0]                pixel_value;

	modport source (output valid, command, coef_index, coef_value, pixel_value, input ready);
	modport sink (input valid, command, coef_index, coef_value, pixel_value, output ready);
endinterface

interface mc2d_out_if #(
	parameter int SUM_BITS = 37
);
	logic                           valid;
	logic                           ready;
	logic [mc2d_pkg::POS_BITS-1:0]  out_row;
	logic [mc2d_pkg::POS_BITS-1:0]  out_col;
	logic signed [SUM_BITS-1:0]     filtered_value;
	logic                           frame_end;

	modport source (output valid, out_row, out_col, filtered_value, frame_end, input ready);
	modport sink (input valid, out_row, out_col, filtered_value, frame_end, output ready);
endinterface

@@ src/mirrored_2d_convolution.sv @@
`timescale 1ns / 1ps
// A result passes registers s1 to s4 of the MAC after its item is accepted.
// One item per cycle unless stalled; each item reads every line store bank copy once.
// A result shows up after a lag of half*width+half pixels; drain items flush the rest.
// Reset clears counters and coefficients, loads 640x480 with half 1; the line store
// is not cleared and needs no clearing pass.
module mirrored_2d_convolution #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HALF   = 2,
	parameter int PIXEL_BITS = 16,
	parameter int COEF_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mc2d_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [mc2d_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [mc2d_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	mc2d_in_if.sink                              stream_in,
	mc2d_out_if.source                           stream_out
);
	localparam int KSIDE = 2 * MAX_HALF + 1;
	localparam int NCOEF = KSIDE * KSIDE;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int HB    = $clog2(MAX_HALF + 1);
	localparam int BK    = $clog2(KSIDE);

	mc2d_pkg::cfg_regs_t         cfg;
	mc2d_pkg::emit_t             emit;
	logic                        advance, accept;
	logic [CW-1:0]               col_addr [KSIDE];
	logic [BK-1:0]               bank_sel [KSIDE];
	logic                        wr_en;
	logic [BK-1:0]               wr_bank;
	logic [CW-1:0]               wr_col;
	logic [PIXEL_BITS-1:0]       wr_data;
	logic signed [COEF_BITS-1:0] coef [NCOEF];
	logic [HB-1:0]               eff_k;
	logic [PIXEL_BITS-1:0]       tap [KSIDE][KSIDE];

	assign stream_in.ready = advance;
	assign accept          = stream_in.valid & advance;

	mc2d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mc2d_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HALF   (MAX_HALF),
		.PIXEL_BITS (PIXEL_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.command     (stream_in.command),
		.coef_index  (stream_in.coef_index),
		.coef_value  (stream_in.coef_value),
		.pixel_value (stream_in.pixel_value),
		.emit        (emit),
		.col_addr    (col_addr),
		.bank_sel    (bank_sel),
		.wr_en       (wr_en),
		.wr_bank     (wr_bank),
		.wr_col      (wr_col),
		.wr_data     (wr_data),
		.coef        (coef),
		.eff_k       (eff_k)
	);

	mc2d_line_mem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HALF   (MAX_HALF),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_mem (
		.clk      (clk),
		.en       (advance),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_col   (wr_col),
		.wr_data  (wr_data),
		.col_addr (col_addr),
		.bank_sel (bank_sel),
		.tap      (tap)
	);

	mc2d_mac #(
		.MAX_HALF   (MAX_HALF),
		.PIXEL_BITS (PIXEL_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_mac (
		.clk            (clk),
		.arst_n         (arst_n),
		.emit           (emit),
		.eff_k          (eff_k),
		.coef           (coef),
		.tap            (tap),
		.out_ready      (stream_out.ready),
		.advance        (advance),
		.out_valid      (stream_out.valid),
		.out_row        (stream_out.out_row),
		.out_col        (stream_out.out_col),
		.filtered_value (stream_out.filtered_value),
		.frame_end      (stream_out.frame_end)
	);
endmodule

@@ src/mc2d_cfg.sv @@
`timescale 1ns / 1ps
// APB register file: frame width, frame height and kernel half size.
module mc2d_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mc2d_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [mc2d_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [mc2d_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                   pready,
	output mc2d_pkg::cfg_regs_t                    cfg
);
	logic [mc2d_pkg::DIM_BITS-1:0]  width_q;
	logic [mc2d_pkg::DIM_BITS-1:0]  height_q;
	logic [mc2d_pkg::HALF_BITS-1:0] half_q;
	logic                           wr_en;
	mc2d_pkg::reg_idx_t             idx;

	assign pready = 1'b1;
	assign idx    = mc2d_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mc2d_pkg::WIDTH_RESET;
			height_q <= mc2d_pkg::HEIGHT_RESET;
			half_q   <= mc2d_pkg::HALF_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mc2d_pkg::REG_WIDTH:  width_q  <= pwdata[mc2d_pkg::DIM_BITS-1:0];
				mc2d_pkg::REG_HEIGHT: height_q <= pwdata[mc2d_pkg::DIM_BITS-1:0];
				mc2d_pkg::REG_HALF:   half_q   <= pwdata[mc2d_pkg::HALF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mc2d_pkg::REG_WIDTH:  prdata = {20'd0, width_q};
			mc2d_pkg::REG_HEIGHT: prdata = {20'd0, height_q};
			mc2d_pkg::REG_HALF:   prdata = {30'd0, half_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.width   = width_q;
	assign cfg.height  = height_q;
	assign cfg.half    = half_q;
	assign cfg.restart = wr_en && (idx == mc2d_pkg::REG_WIDTH || idx == mc2d_pkg::REG_HEIGHT
		|| idx == mc2d_pkg::REG_HALF);
endmodule

@@ src/mc2d_ctrl.sv @@
`timescale 1ns / 1ps
// Frame counters, coefficient registers and mirrored tap address generation.
module mc2d_ctrl #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HALF   = 2,
	parameter int PIXEL_BITS = 16,
	parameter int COEF_BITS  = 16,
	localparam int KSIDE     = 2 * MAX_HALF + 1,
	localparam int NCOEF     = KSIDE * KSIDE,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int HB        = $clog2(MAX_HALF + 1),
	localparam int BK        = $clog2(KSIDE)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mc2d_pkg::cfg_regs_t              cfg,
	input  logic                             accept,
	input  logic [mc2d_pkg::CMD_BITS-1:0]    command,
	input  logic [mc2d_pkg::CIDX_BITS-1:0]   coef_index,
	input  logic signed [COEF_BITS-1:0]      coef_value,
	input  logic [PIXEL_BITS-1:0]            pixel_value,
	output mc2d_pkg::emit_t                  emit,
	output logic [CW-1:0]                    col_addr [KSIDE],
	output logic [BK-1:0]                    bank_sel [KSIDE],
	output logic                             wr_en,
	output logic [BK-1:0]                    wr_bank,
	output logic [CW-1:0]                    wr_col,
	output logic [PIXEL_BITS-1:0]            wr_data,
	output logic signed [COEF_BITS-1:0]      coef [NCOEF],
	output logic [HB-1:0]                    eff_k
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DW = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 1);
	localparam int RB = mc2d_pkg::POS_BITS;
	localparam int HW = mc2d_pkg::DIM_BITS;

	logic [WW-1:0]  eff_w;
	logic [HW-1:0]  eff_h;
	logic [DW-1:0]  lag;
	logic [RB-1:0]  in_row_q, out_row_q;
	logic [CW-1:0]  in_col_q, out_col_q;
	logic [BK-1:0]  in_bank_q, out_bank_q;
	logic [DW-1:0]  diff_q;
	logic           frame_q;
	mc2d_pkg::cmd_t cmd;
	logic           is_pix, is_drain, wr, emit_go, last;
	logic           in_col_end, in_row_end;

	always_comb begin
		if (cfg.width == '0) begin
			eff_w = WW'(1);
		end else if (int'(cfg.width) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.width);
		end
		if (cfg.height == '0) begin
			eff_h = HW'(1);
		end else if (int'(cfg.height) > mc2d_pkg::MAX_HEIGHT) begin
			eff_h = HW'(mc2d_pkg::MAX_HEIGHT);
		end else begin
			eff_h = cfg.height;
		end
		if (int'(cfg.half) > MAX_HALF) begin
			eff_k = HB'(MAX_HALF);
		end else begin
			eff_k = HB'(cfg.half);
		end
	end

	assign lag = DW'(eff_k) * DW'(eff_w) + DW'(eff_k);

	assign cmd        = mc2d_pkg::cmd_t'(command);
	assign is_pix     = accept && cmd == mc2d_pkg::CMD_PIXEL;
	assign is_drain   = accept && cmd == mc2d_pkg::CMD_DRAIN;
	assign wr         = is_pix && !frame_q;
	assign emit_go    = ((is_pix || is_drain) && frame_q) || (wr && diff_q >= lag);
	assign last       = ({1'b0, out_row_q} == eff_h - HW'(1))
		&& (WW'(out_col_q) == eff_w - WW'(1));
	assign in_col_end = WW'(in_col_q) == eff_w - WW'(1);
	assign in_row_end = {1'b0, in_row_q} == eff_h - HW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_bank_q <= '0;
			diff_q     <= '0;
			frame_q    <= 1'b0;
		end else if (cfg.restart) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_bank_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_bank_q <= '0;
			diff_q     <= '0;
			frame_q    <= 1'b0;
		end else begin
			if (wr) begin
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_end) begin
						in_row_q  <= '0;
						in_bank_q <= '0;
						frame_q   <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + RB'(1);
						in_bank_q <= (in_bank_q == BK'(KSIDE - 1)) ? '0 : in_bank_q + BK'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (wr && !emit_go) begin
				diff_q <= diff_q + DW'(1);
			end
			if (emit_go) begin
				if (last) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					in_bank_q  <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_bank_q <= '0;
					diff_q     <= '0;
					frame_q    <= 1'b0;
				end else if (WW'(out_col_q) == eff_w - WW'(1)) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + RB'(1);
					out_bank_q <= (out_bank_q == BK'(KSIDE - 1)) ? '0 : out_bank_q + BK'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NCOEF; n++) begin
				coef[n] <= '0;
			end
		end else if (accept && cmd == mc2d_pkg::CMD_COEF) begin
			for (int n = 0; n < NCOEF; n++) begin
				if (int'(coef_index) == n) begin
					coef[n] <= coef_value;
				end
			end
		end
	end

	// row y of the ring sits in bank y mod KSIDE; y stays within MAX_HALF of the center row
	always_comb begin
		int y, t;
		for (int j = 0; j < KSIDE; j++) begin
			col_addr[j] = CW'(mc2d_pkg::mirror(int'(out_col_q) + j - MAX_HALF, int'(eff_w)));
		end
		for (int i = 0; i < KSIDE; i++) begin
			y = mc2d_pkg::mirror(int'(out_row_q) + i - MAX_HALF, int'(eff_h));
			t = int'(out_bank_q) + y - int'(out_row_q);
			if (t < 0) begin
				t = t + KSIDE;
			end else if (t >= KSIDE) begin
				t = t - KSIDE;
			end
			bank_sel[i] = BK'(t);
		end
	end

	assign emit.valid = emit_go;
	assign emit.row   = out_row_q;
	assign emit.col   = RB'(out_col_q);
	assign emit.last  = last;

	assign wr_en   = wr;
	assign wr_bank = in_bank_q;
	assign wr_col  = in_col_q;
	assign wr_data = pixel_value;
endmodule

@@ src/mc2d_line_mem.sv @@
`timescale 1ns / 1ps
// Line store: one bank per ring row, replicated per kernel column, with write forwarding.
module mc2d_line_mem #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HALF   = 2,
	parameter int PIXEL_BITS = 16,
	localparam int KSIDE     = 2 * MAX_HALF + 1,
	localparam int CW        = $clog2(MAX_WIDTH),
	localparam int BK        = $clog2(KSIDE)
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  wr_en,
	input  logic [BK-1:0]         wr_bank,
	input  logic [CW-1:0]         wr_col,
	input  logic [PIXEL_BITS-1:0] wr_data,
	input  logic [CW-1:0]         col_addr [KSIDE],
	input  logic [BK-1:0]         bank_sel [KSIDE],
	output logic [PIXEL_BITS-1:0] tap [KSIDE][KSIDE]
);
	logic [PIXEL_BITS-1:0] rd_s1 [KSIDE][KSIDE];
	logic                  fwd_s1 [KSIDE][KSIDE];
	logic [PIXEL_BITS-1:0] wdata_s1;
	logic [BK-1:0]         bsel_s1 [KSIDE];

	for (genvar b = 0; b < KSIDE; b++) begin : g_bank
		for (genvar j = 0; j < KSIDE; j++) begin : g_copy
			logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];

			always_ff @(posedge clk) begin
				if (wr_en && wr_bank == BK'(b)) begin
					mem[wr_col] <= wr_data;
				end
				if (en) begin
					rd_s1[b][j]  <= mem[col_addr[j]];
					fwd_s1[b][j] <= wr_en && wr_bank == BK'(b) && wr_col == col_addr[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wdata_s1 <= wr_data;
			bsel_s1  <= bank_sel;
		end
	end

	always_comb begin
		for (int i = 0; i < KSIDE; i++) begin
			for (int j = 0; j < KSIDE; j++) begin
				tap[i][j] = '0;
				for (int b = 0; b < KSIDE; b++) begin
					if (bsel_s1[i] == BK'(b)) begin
						tap[i][j] = fwd_s1[b][j] ? wdata_s1 : rd_s1[b][j];
					end
				end
			end
		end
	end
endmodule

@@ src/mc2d_mac.sv @@
`timescale 1ns / 1ps
// Multiply-accumulate pipeline: tap products, row sums, total and output register.
module mc2d_mac #(
	parameter int MAX_HALF   = 2,
	parameter int PIXEL_BITS = 16,
	parameter int COEF_BITS  = 16,
	localparam int KSIDE     = 2 * MAX_HALF + 1,
	localparam int NCOEF     = KSIDE * KSIDE,
	localparam int HB        = $clog2(MAX_HALF + 1),
	localparam int SUM_BITS  = PIXEL_BITS + COEF_BITS + $clog2(NCOEF)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mc2d_pkg::emit_t                   emit,
	input  logic [HB-1:0]                     eff_k,
	input  logic signed [COEF_BITS-1:0]       coef [NCOEF],
	input  logic [PIXEL_BITS-1:0]             tap [KSIDE][KSIDE],
	input  logic                              out_ready,
	output logic                              advance,
	output logic                              out_valid,
	output logic [mc2d_pkg::POS_BITS-1:0]     out_row,
	output logic [mc2d_pkg::POS_BITS-1:0]     out_col,
	output logic signed [SUM_BITS-1:0]        filtered_value,
	output logic                              frame_end
);
	localparam int PW = PIXEL_BITS + COEF_BITS + 1;

	mc2d_pkg::emit_t             meta_s1, meta_s2, meta_s3, meta_s4;
	logic                        en1, en2, en3, en4;
	logic signed [COEF_BITS-1:0] coef_tap [KSIDE][KSIDE];
	logic                        tap_on [KSIDE][KSIDE];
	logic signed [PW-1:0]        prod_s2 [KSIDE][KSIDE];
	logic signed [SUM_BITS-1:0]  row_sum [KSIDE];
	logic signed [SUM_BITS-1:0]  row_s3 [KSIDE];
	logic signed [SUM_BITS-1:0]  total;
	logic signed [SUM_BITS-1:0]  total_s4;

	assign en4     = !meta_s4.valid || out_ready;
	assign en3     = !meta_s3.valid || en4;
	assign en2     = !meta_s2.valid || en3;
	assign en1     = !meta_s1.valid || en2;
	assign advance = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
		end else begin
			if (en1) meta_s1 <= emit;
			if (en2) meta_s2 <= meta_s1;
			if (en3) meta_s3 <= meta_s2;
			if (en4) meta_s4 <= meta_s3;
		end
	end

	// taps outside the active kernel get a zero weight and a zero pixel
	always_comb begin
		for (int i = 0; i < KSIDE; i++) begin
			for (int j = 0; j < KSIDE; j++) begin
				coef_tap[i][j] = '0;
				tap_on[i][j]   = 1'b0;
				for (int kk = 0; kk <= MAX_HALF; kk++) begin
					if (int'(eff_k) == kk && i >= MAX_HALF - kk && i <= MAX_HALF + kk
						&& j >= MAX_HALF - kk && j <= MAX_HALF + kk) begin
						coef_tap[i][j] = coef[(i - MAX_HALF + kk) * KSIDE + (j - MAX_HALF + kk)];
						tap_on[i][j]   = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < KSIDE; i++) begin
				for (int j = 0; j < KSIDE; j++) begin
					prod_s2[i][j] <= $signed({1'b0,
						tap_on[i][j] ? tap[i][j] : {PIXEL_BITS{1'b0}}}) * coef_tap[i][j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KSIDE; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < KSIDE; j++) begin
				row_sum[i] = row_sum[i] + SUM_BITS'(prod_s2[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) row_s3 <= row_sum;
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < KSIDE; i++) begin
			total = total + row_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) total_s4 <= total;
	end

	assign out_valid      = meta_s4.valid;
	assign out_row        = meta_s4.row;
	assign out_col        = meta_s4.col;
	assign frame_end      = meta_s4.last;
	assign filtered_value = total_s4;
endmodule

@@ sim/mc2d_checker.sv @@
`timescale 1ns / 1ps
// Checker: watches config writes and both streams, predicts filtered pixels, compares.
module mc2d_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mc2d_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [mc2d_pkg::APB_DATA_BITS-1:0]   pwdata,
	input  logic                                 pready,
	mc2d_in_if                                   inp,
	mc2d_out_if                                  outp,
	output int                                   errors,
	output int                                   pending
);
	localparam int SIDE  = 5;
	localparam int LINE  = 2048;

	typedef struct {
		logic [mc2d_pkg::POS_BITS-1:0] row;
		logic [mc2d_pkg::POS_BITS-1:0] col;
		logic [36:0]                   sum;
		logic                          last;
	} pixel_result_t;

	pixel_result_t     expected_px[$];
	logic [15:0]       lines [0:SIDE*LINE-1];
	int                coefs [0:SIDE*SIDE-1];
	int                in_r, in_c, o_r, o_c;
	bit                received;
	logic [11:0]       width_reg, height_reg;
	logic [1:0]        half_reg;

	function automatic int cur_w();
		if (width_reg == 0) return 1;
		if (width_reg > LINE) return LINE;
		return int'(width_reg);
	endfunction

	function automatic int cur_h();
		if (height_reg == 0) return 1;
		if (height_reg > mc2d_pkg::MAX_HEIGHT) return mc2d_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic int cur_k();
		return (half_reg > 2) ? 2 : int'(half_reg);
	endfunction

	function automatic int fold(input int i, input int dim);
		int m;
		m = (i < 0) ? -i : ((i >= dim) ? 2 * dim - i - 1 : i);
		if (m < 0) m = 0;
		if (m >= dim) m = dim - 1;
		return m;
	endfunction

	task automatic restart_frame();
		in_r = 0;
		in_c = 0;
		o_r = 0;
		o_c = 0;
		received = 0;
	endtask

	task automatic filter_next();
		int w, h, k, y, x;
		longint acc;
		pixel_result_t px;
		w = cur_w();
		h = cur_h();
		k = cur_k();
		acc = 0;
		for (int dy = -k; dy <= k; dy++) begin
			y = fold(o_r + dy, h) % SIDE;
			for (int dx = -k; dx <= k; dx++) begin
				x = fold(o_c + dx, w);
				acc += longint'(lines[y*LINE + x]) * longint'(coefs[(dy+k)*SIDE + dx + k]);
			end
		end
		px.row = o_r[mc2d_pkg::POS_BITS-1:0];
		px.col = o_c[mc2d_pkg::POS_BITS-1:0];
		px.sum = acc[36:0];
		px.last = (o_r == h - 1) && (o_c == w - 1);
		expected_px.push_back(px);
		if (px.last) begin
			restart_frame();
		end else begin
			o_c++;
			if (o_c >= w) begin
				o_c = 0;
				o_r++;
			end
		end
	endtask

	task automatic take_item(input mc2d_pkg::cmd_t cmd, input logic [4:0] idx,
			input logic [15:0] cv, input logic [15:0] pix);
		int w, h, k;
		longint p, q, lag;
		if (cmd == mc2d_pkg::CMD_COEF) begin
			if (idx < SIDE * SIDE) coefs[idx] = int'($signed(cv));
		end else if (cmd == mc2d_pkg::CMD_DRAIN || (cmd == mc2d_pkg::CMD_PIXEL && received)) begin
			if (received) filter_next();
		end else if (cmd == mc2d_pkg::CMD_PIXEL) begin
			w = cur_w();
			h = cur_h();
			k = cur_k();
			p = longint'(in_r) * w + in_c;
			q = longint'(o_r) * w + o_c;
			lag = longint'(k) * w + k;
			lines[(in_r % SIDE)*LINE + in_c] = pix;
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
				if (in_r >= h) begin
					in_r = 0;
					received = 1;
				end
			end
			if (p >= q + lag) filter_next();
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t px;
		if (!arst_n) begin
			errors = 0;
			expected_px.delete();
			for (int i = 0; i < SIDE * SIDE; i++) coefs[i] = 0;
			for (int i = 0; i < SIDE * LINE; i++) lines[i] = '0;
			width_reg = mc2d_pkg::WIDTH_RESET;
			height_reg = mc2d_pkg::HEIGHT_RESET;
			half_reg = mc2d_pkg::HALF_RESET;
			restart_frame();
		end else begin
			if (outp.valid && outp.ready) begin
				if (expected_px.size() == 0) begin
					report("unexpected item row", outp.out_row, -1);
				end else begin
					px = expected_px.pop_front();
					if (outp.out_row !== px.row) report("out_row", outp.out_row, px.row);
					if (outp.out_col !== px.col) report("out_col", outp.out_col, px.col);
					if (outp.filtered_value !== px.sum)
						report("filtered_value", $signed(outp.filtered_value),
							$signed(px.sum));
					if (outp.frame_end !== px.last)
						report("frame_end", outp.frame_end, px.last);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					mc2d_pkg::REG_WIDTH: begin
						width_reg = pwdata[11:0];
						restart_frame();
					end
					mc2d_pkg::REG_HEIGHT: begin
						height_reg = pwdata[11:0];
						restart_frame();
					end
					mc2d_pkg::REG_HALF: begin
						half_reg = pwdata[1:0];
						restart_frame();
					end
					default: ;
				endcase
			end
			if (inp.valid && inp.ready)
				take_item(mc2d_pkg::cmd_t'(inp.command), inp.coef_index, inp.coef_value,
					inp.pixel_value);
		end
		pending = expected_px.size();
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, config writes, command item stimulus and verdict.
module tb_top;
	localparam int LIMIT = 600000;
	localparam int AW    = mc2d_pkg::APB_ADDR_BITS;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 psel, penable, pwrite;
	logic [mc2d_pkg::APB_ADDR_BITS-1:0]   paddr;
	logic [mc2d_pkg::APB_DATA_BITS-1:0]   pwdata;
	logic [mc2d_pkg::APB_DATA_BITS-1:0]   prdata;
	logic                                 pready;
	int                                   errors, pending;
	int                                   idle_pct, stall_pct;
	int                                   cycles;

	mc2d_in_if  stream_in ();
	mc2d_out_if stream_out ();

	mirrored_2d_convolution dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.stream_in(stream_in), .stream_out(stream_out)
	);

	mc2d_checker checker_i (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .inp(stream_in),
		.outp(stream_out), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		stream_out.ready <= ($urandom_range(0, 99) >= stall_pct);
		if (cycles > LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic reg_write(input mc2d_pkg::reg_idx_t idx, input logic [11:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= AW'(idx) << 2;
		pwdata <= {20'($urandom_range(0, 1048575)), val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	task automatic send(input mc2d_pkg::cmd_t cmd, input logic [4:0] idx,
			input logic [15:0] cv, input logic [15:0] pix);
		while ($urandom_range(0, 99) < idle_pct) begin
			stream_in.valid <= 0;
			@(posedge clk);
		end
		stream_in.valid <= 1;
		stream_in.command <= cmd;
		stream_in.coef_index <= idx;
		stream_in.coef_value <= cv;
		stream_in.pixel_value <= pix;
		@(posedge clk);
		while (!stream_in.ready) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [15:0] pix);
		send(mc2d_pkg::CMD_PIXEL, 5'($urandom_range(0, 31)), 16'($urandom), pix);
	endtask

	task automatic send_drain();
		send(mc2d_pkg::CMD_DRAIN, 5'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic settle();
		stream_in.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);
	endtask

	// one frame: config, coefficients, pixels with optional noise, drains
	task automatic frame(input logic [11:0] wr, input logic [11:0] hr, input logic [1:0] kr,
			input bit noisy, input bit extreme);
		int w, h, k, total, lag, drains;
		settle();
		reg_write(mc2d_pkg::REG_WIDTH, wr);
		reg_write(mc2d_pkg::REG_HEIGHT, hr);
		reg_write(mc2d_pkg::REG_HALF, {10'd0, kr});
		w = (wr == 0) ? 1 : ((wr > 2048) ? 2048 : int'(wr));
		h = (hr == 0) ? 1 : ((hr > 2048) ? 2048 : int'(hr));
		k = (kr > 2) ? 2 : int'(kr);
		total = w * h;
		lag = k * w + k;
		drains = (lag < total) ? lag : total;
		for (int i = 0; i < 25; i++)
			if (extreme) send(mc2d_pkg::CMD_COEF, 5'(i), (i % 2) ? 16'h7fff : 16'h8000,
				16'($urandom));
			else if ($urandom_range(0, 2) != 0)
				send(mc2d_pkg::CMD_COEF, 5'(i), 16'($urandom), 16'($urandom));
		if (noisy) send_drain();
		for (int i = 0; i < total; i++) begin
			if (extreme) send_pixel((i % 2) ? 16'hffff : 16'h0000);
			else send_pixel(16'($urandom));
			if (noisy && $urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: send(mc2d_pkg::CMD_NOP, 5'($urandom), 16'($urandom), 16'($urandom));
					1: send(mc2d_pkg::CMD_COEF, 5'($urandom_range(25, 31)), 16'($urandom),
						16'($urandom));
					2: send(mc2d_pkg::CMD_COEF, 5'($urandom_range(0, 24)), 16'($urandom),
						16'($urandom));
					default: send_drain();
				endcase
			end
		end
		if (noisy && total == 1 && drains == 0) send_drain();
		for (int i = 0; i < drains; i++)
			if (noisy && $urandom_range(0, 3) == 0) send_pixel(16'($urandom));
			else send_drain();
		if (noisy) send_drain();
	endtask

	task automatic random_frames(input int n);
		logic [1:0] kr;
		logic [11:0] wr;
		for (int f = 0; f < n; f++) begin
			kr = 2'($urandom_range(0, 3));
			wr = (kr >= 2) ? 12'($urandom_range(5, 10)) : 12'($urandom_range(1, 10));
			frame(wr, 12'($urandom_range(1, 7)), kr, 1, 0);
			if (f == 1) begin
				send_pixel(16'($urandom));
				stream_in.valid <= 0;
				@(posedge clk);
				wait (pending == 0);
			end
		end
	endtask

	initial begin
		cycles = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		stream_in.valid = 0;
		stream_in.command = mc2d_pkg::CMD_NOP;
		stream_in.coef_index = '0;
		stream_in.coef_value = '0;
		stream_in.pixel_value = '0;
		stream_out.ready = 0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send(mc2d_pkg::CMD_DRAIN, 5'd0, 16'd0, 16'd0);
		send(mc2d_pkg::CMD_NOP, 5'h1f, 16'hffff, 16'hffff);
		frame(12'd1, 12'd1, 2'd0, 0, 1);
		frame(12'd0, 12'd0, 2'd3, 1, 1);
		frame(12'd5, 12'd3, 2'd2, 0, 1);
		frame(12'd4, 12'd2, 2'd1, 1, 0);

		// random phases
		random_frames(2);
		idle_pct = 57;
		random_frames(2);
		idle_pct = 0;
		stall_pct = 57;
		random_frames(2);
		idle_pct = 27;
		stall_pct = 27;
		random_frames(2);
		idle_pct = 0;
		stall_pct = 0;

		settle();
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/mc2d_pkg.sv
src/mc2d_if.sv
src/mc2d_cfg.sv
src/mc2d_ctrl.sv
src/mc2d_line_mem.sv
src/mc2d_mac.sv
src/mirrored_2d_convolution.sv
sim/mc2d_checker.sv
sim/tb_top.sv
